/* src/date_day_number_weekday_week_assert.svh */
// Assertion macros shared by the date decoder.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef DATE_DAY_NUMBER_WEEKDAY_WEEK_ASSERT_SVH
`define DATE_DAY_NUMBER_WEEKDAY_WEEK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDNW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDNW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ddnw_pkg.sv */
package ddnw_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int DOY_W    = 9;
    localparam int DN_W     = 22;
    localparam int WDAY_W   = 3;
    localparam int WEEK_W   = 6;

    // Full-width day count before truncation to the output field.
    localparam int DAYS_W   = 23;
    // Year quarter (year / 4) width.
    localparam int YQ_W     = YEAR_W - 2;

    localparam int NUM_STAGES = 5;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR    = YEAR_W'(1601);
    localparam logic [DOY_W-1:0]  DAYS_PER_YEAR = DOY_W'(365);

    // x / 25 == (x * 2622) >> 16 for every 12-bit x.
    localparam int               RECIP25_SHIFT = 16;
    localparam int               PROD25_W      = 2 * YQ_W;
    localparam int               Q25_W         = PROD25_W - RECIP25_SHIFT;
    localparam logic [YQ_W-1:0]  RECIP25       = YQ_W'(2622);
    localparam logic [YQ_W-1:0]  TWENTY_FIVE   = YQ_W'(25);

    // x / 7 == (x * 586) >> 12 for every x below 682.
    localparam int               RECIP7_SHIFT  = 12;
    localparam int               RECIP7_W      = 10;
    localparam int               PROD7_W       = DOY_W + RECIP7_W;
    localparam logic [RECIP7_W-1:0] RECIP7     = RECIP7_W'(586);

    localparam int MOD7_IN_W = 24;

    typedef logic [YEAR_W-1:0]  year_t;
    typedef logic [MONTH_W-1:0] month_t;
    typedef logic [DAY_W-1:0]   day_t;
    typedef logic [DOY_W-1:0]   doy_t;
    typedef logic [DN_W-1:0]    day_number_t;
    typedef logic [WDAY_W-1:0]  weekday_t;
    typedef logic [WEEK_W-1:0]  week_t;
    typedef logic [DAYS_W-1:0]  days_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DAY   = 2'd1,
        ST_PRE_EPOCH = 2'd2
    } status_t;

    localparam month_t MONTH_JAN = MONTH_W'(1);
    localparam month_t MONTH_FEB = MONTH_W'(2);
    localparam month_t MONTH_APR = MONTH_W'(4);
    localparam month_t MONTH_JUN = MONTH_W'(6);
    localparam month_t MONTH_SEP = MONTH_W'(9);
    localparam month_t MONTH_NOV = MONTH_W'(11);
    localparam month_t MONTH_DEC = MONTH_W'(12);

    // Days before the first of the month in a common year.
    function automatic doy_t days_before(input month_t m);
        doy_t d;
        case (m)
            4'd1:    d = DOY_W'(0);
            4'd2:    d = DOY_W'(31);
            4'd3:    d = DOY_W'(59);
            4'd4:    d = DOY_W'(90);
            4'd5:    d = DOY_W'(120);
            4'd6:    d = DOY_W'(151);
            4'd7:    d = DOY_W'(181);
            4'd8:    d = DOY_W'(212);
            4'd9:    d = DOY_W'(243);
            4'd10:   d = DOY_W'(273);
            4'd11:   d = DOY_W'(304);
            4'd12:   d = DOY_W'(334);
            default: d = DOY_W'(0);
        endcase
        return d;
    endfunction

    function automatic day_t month_len(input month_t m, input logic leap);
        day_t len;
        if (m == MONTH_FEB)
        begin
            len = leap ? DAY_W'(29) : DAY_W'(28);
        end
        else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
        begin
            len = DAY_W'(30);
        end
        else
        begin
            len = DAY_W'(31);
        end
        return len;
    endfunction

    // Residue mod 7 by folding octal digits, since 8 is 1 mod 7.
    function automatic logic [2:0] mod7(input logic [MOD7_IN_W-1:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = '0;
        for (int i = 0; i < MOD7_IN_W / 3; i++)
        begin
            s1 = s1 + 6'(x[3*i +: 3]);
        end
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        s3 = 4'(s2[3]) + 4'(s2[2:0]);
        return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
    endfunction

endpackage

/* src/date_day_number_weekday_week.sv */
// Channel  Valid       Stall       Beat fields
// -------  ----------  ----------  ----------------------------------------------
// date     date_valid  date_stall  year, month, day
// result   res_valid   res_stall   status, leap, ordinal_day, day_number,
//                                  weekday, week_number
//
// Five register stages; a date beat may enter every cycle when the result side
// does not stall, and its result beat leaves through the result register.
// The pipeline depth follows from the work split: constant multiplies by reciprocals,
// the day count adder and the mod-7 digit folds each take their own stage.
// Reset (rst_n low, asynchronous) empties every stage; no data is cleared.
// A stall holds only the stages that are full and blocked; empty stages
// further back keep filling, so bubbles are squeezed out under back pressure.
module date_day_number_weekday_week
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  date_valid,
    output logic                  date_stall,
    input  ddnw_pkg::year_t       year,
    input  ddnw_pkg::month_t      month,
    input  ddnw_pkg::day_t        day,

    output logic                  res_valid,
    input  logic                  res_stall,
    output ddnw_pkg::status_t     status,
    output logic                  leap,
    output ddnw_pkg::doy_t        ordinal_day,
    output ddnw_pkg::day_number_t day_number,
    output ddnw_pkg::weekday_t    weekday,
    output ddnw_pkg::week_t       week_number
);

    import ddnw_pkg::*;

    // Pipeline control. Stage k may load when it is empty or when the stage
    // after it loads in the same cycle; the last stage is the result register.
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] rdy;

    always_comb
    begin
        rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || !res_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign date_stall = !rdy[0];
    assign res_valid  = vld_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= date_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage 1: years since the epoch and the three constant products.
    year_t                 s1_year_reg;
    month_t                s1_month_reg;
    day_t                  s1_day_reg;
    logic [YEAR_W-1:0]     s1_yy_reg, s1_yy_next;
    logic                  s1_pre_reg, s1_pre_next;
    logic [PROD25_W-1:0]   s1_py100_reg, s1_py100_next;
    logic [PROD25_W-1:0]   s1_pyy100_reg, s1_pyy100_next;
    days_t                 s1_p365_reg, s1_p365_next;

    always_comb
    begin
        // Wraps for years before the epoch; the wrapped values never reach the output fields.
        s1_yy_next     = year - EPOCH_YEAR;
        s1_pre_next    = year < EPOCH_YEAR;
        s1_py100_next  = PROD25_W'(year[YEAR_W-1:2]) * PROD25_W'(RECIP25);
        s1_pyy100_next = PROD25_W'(s1_yy_next[YEAR_W-1:2]) * PROD25_W'(RECIP25);
        s1_p365_next   = DAYS_W'(s1_yy_next) * DAYS_W'(DAYS_PER_YEAR);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_year_reg   <= year;
            s1_month_reg  <= month;
            s1_day_reg    <= day;
            s1_yy_reg     <= s1_yy_next;
            s1_pre_reg    <= s1_pre_next;
            s1_py100_reg  <= s1_py100_next;
            s1_pyy100_reg <= s1_pyy100_next;
            s1_p365_reg   <= s1_p365_next;
        end
    end

    // Stage 2: leap flag, status, day of year and days up to January 1.
    // year / 100 is (year / 4) / 25, and year / 400 is that quotient / 4.
    logic [Q25_W-1:0]  s2_qy;
    logic [Q25_W-1:0]  s2_qyy;
    logic              s2_div100;
    day_t              s2_mlen;
    logic              s2_bad_day;
    status_t           s2_status_reg, s2_status_next;
    logic              s2_leap_reg, s2_leap_next;
    doy_t              s2_doy_reg, s2_doy_next;
    days_t             s2_days_reg, s2_days_next;

    always_comb
    begin
        s2_qy     = s1_py100_reg[RECIP25_SHIFT +: Q25_W];
        s2_qyy    = s1_pyy100_reg[RECIP25_SHIFT +: Q25_W];
        s2_div100 = (YQ_W'(s2_qy) * TWENTY_FIVE) == s1_year_reg[YEAR_W-1:2];
        s2_leap_next = (s1_year_reg[1:0] == 2'b00) && (!s2_div100 || (s2_qy[1:0] == 2'b00));

        s2_mlen    = month_len(s1_month_reg, s2_leap_next);
        s2_bad_day = (s1_month_reg < MONTH_JAN) || (s1_month_reg > MONTH_DEC)
                     || (s1_day_reg == '0) || (s1_day_reg > s2_mlen);

        if (s2_bad_day)
        begin
            s2_status_next = ST_BAD_DAY;
        end
        else if (s1_pre_reg)
        begin
            s2_status_next = ST_PRE_EPOCH;
        end
        else
        begin
            s2_status_next = ST_OK;
        end

        s2_doy_next = days_before(s1_month_reg) + DOY_W'(s1_day_reg)
                      + DOY_W'((s1_month_reg > MONTH_FEB) && s2_leap_next);

        s2_days_next = s1_p365_reg + DAYS_W'(s1_yy_reg[YEAR_W-1:2])
                       - DAYS_W'(s2_qyy) + DAYS_W'(s2_qyy[Q25_W-1:2]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s2_status_reg <= s2_status_next;
            s2_leap_reg   <= s2_leap_next;
            s2_doy_reg    <= s2_doy_next;
            s2_days_reg   <= s2_days_next;
        end
    end

    // Stage 3: day number and the two residues mod 7.
    // January 1 of the year falls on weekday (days + 1) mod 7, so the
    // Monday-based weekday of January 1 is simply days mod 7.
    status_t           s3_status_reg;
    logic              s3_leap_reg;
    doy_t              s3_doy_reg;
    days_t             s3_dn_reg, s3_dn_next;
    logic [2:0]        s3_mon0_reg, s3_mon0_next;
    logic [2:0]        s3_doy7_reg, s3_doy7_next;

    always_comb
    begin
        s3_dn_next   = s2_days_reg + DAYS_W'(s2_doy_reg) - DAYS_W'(1);
        s3_mon0_next = mod7(MOD7_IN_W'(s2_days_reg));
        s3_doy7_next = mod7(MOD7_IN_W'(s2_doy_reg));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            s3_status_reg <= s2_status_reg;
            s3_leap_reg   <= s2_leap_reg;
            s3_doy_reg    <= s2_doy_reg;
            s3_dn_reg     <= s3_dn_next;
            s3_mon0_reg   <= s3_mon0_next;
            s3_doy7_reg   <= s3_doy7_next;
        end
    end

    // Stage 4: weekday and the week numerator times the reciprocal of 7.
    // When January 1 is Monday through Thursday, its week is week 1.
    status_t              s4_status_reg;
    logic                 s4_leap_reg;
    doy_t                 s4_doy_reg;
    day_number_t          s4_dn_reg;
    logic [3:0]           s4_wsum;
    weekday_t             s4_wday_reg, s4_wday_next;
    doy_t                 s4_wnum;
    logic [PROD7_W-1:0]   s4_wprod_reg, s4_wprod_next;

    always_comb
    begin
        s4_wsum      = 4'(s3_mon0_reg) + 4'(s3_doy7_reg);
        s4_wday_next = (s4_wsum >= 4'd7) ? 3'(s4_wsum - 4'd7) : s4_wsum[2:0];
        if (s3_mon0_reg < 3'd4)
        begin
            s4_wnum = s3_doy_reg + DOY_W'(s3_mon0_reg) + DOY_W'(6);
        end
        else
        begin
            s4_wnum = s3_doy_reg + DOY_W'(s3_mon0_reg) - DOY_W'(1);
        end
        s4_wprod_next = PROD7_W'(s4_wnum) * PROD7_W'(RECIP7);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            s4_status_reg <= s3_status_reg;
            s4_leap_reg   <= s3_leap_reg;
            s4_doy_reg    <= s3_doy_reg;
            s4_dn_reg     <= s3_dn_reg[DN_W-1:0];
            s4_wday_reg   <= s4_wday_next;
            s4_wprod_reg  <= s4_wprod_next;
        end
    end

    // Stage 5: result register. Every field but the status reads zero for
    // a date that was rejected.
    status_t       status_reg;
    logic          leap_reg;
    doy_t          ordinal_day_reg;
    day_number_t   day_number_reg;
    weekday_t      weekday_reg;
    week_t         week_number_reg;
    logic          s5_ok;

    assign s5_ok = (s4_status_reg == ST_OK);

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            status_reg      <= s4_status_reg;
            leap_reg        <= s5_ok && s4_leap_reg;
            ordinal_day_reg <= s5_ok ? s4_doy_reg : '0;
            day_number_reg  <= s5_ok ? s4_dn_reg : '0;
            weekday_reg     <= s5_ok ? s4_wday_reg : '0;
            week_number_reg <= s5_ok ? s4_wprod_reg[RECIP7_SHIFT +: WEEK_W] : '0;
        end
    end

    assign status      = status_reg;
    assign leap        = leap_reg;
    assign ordinal_day = ordinal_day_reg;
    assign day_number  = day_number_reg;
    assign weekday     = weekday_reg;
    assign week_number = week_number_reg;

    // Checks on the pipeline and on the result it forms.
`include "date_day_number_weekday_week_assert.svh"

    `DDNW_ASSERT_NEXT(a_accept_fills_first, date_valid && !date_stall, vld_reg[0], "accepted date did not enter the first stage")

    `DDNW_ASSERT_SAME(a_reject_zeroes, res_valid && (status != ST_OK), !leap && (ordinal_day == '0) && (day_number == '0) && (weekday == '0) && (week_number == '0), "rejected date carries nonzero fields")

    `DDNW_ASSERT_SAME(a_ok_ranges, res_valid && (status == ST_OK), (ordinal_day != '0) && (ordinal_day <= (leap ? DOY_W'(366) : DOY_W'(365))) && (weekday <= WDAY_W'(6)) && (week_number <= WEEK_W'(53)), "valid result outside its ranges")

endmodule
